// ===== hw/rtl/gps_pkg.sv =====
// Package for the GA parent selection block.
// Field widths, operation and register codes, and the result struct.
// No dependencies.
package gps_pkg;

   localparam int POP_MAX_DEF  = 64;
   localparam int FIT_BITS     = 32;
   localparam int RAND_BITS    = 16;
   localparam int IDX_BITS     = 6;
   localparam int POPCFG_BITS  = 7;
   localparam int TSIZE_BITS   = 5;
   localparam int TCNT_BITS    = 4;
   localparam int TSIZE_MAX    = 16;
   localparam int CSR_W        = 7;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_ROULETTE = 2'd1;
   localparam logic [1:0] OP_TOURN    = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_POP_COUNT = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TSIZE     = 1'b1;

   localparam logic KIND_ROULETTE = 1'b0;
   localparam logic KIND_TOURN    = 1'b1;

   localparam logic [POPCFG_BITS-1:0] POP_COUNT_RST = 7'd64;
   localparam logic [TSIZE_BITS-1:0]  TSIZE_RST     = 5'd2;

   typedef struct packed {
      logic                valid;
      logic [IDX_BITS-1:0] index;
   } sel_type;

endpackage

// ===== hw/rtl/gps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/gps_roulette.sv =====
// Roulette wheel draw: sequencer, shared accumulator, multiplier and scan compare.
// Depends on gps_pkg; reads the fitness RAM through its read port.
module gps_roulette
   import gps_pkg::*;
#(
   parameter int POP_MAX = POP_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [POPCFG_BITS-1:0]     pop_count,
   input  logic [RAND_BITS-1:0]       random_fraction,
   input  logic [FIT_BITS-1:0]        rd_data,
   output logic [$clog2(POP_MAX)-1:0] rd_addr,
   output logic                       busy,
   output sel_type                    result
);

   localparam int AW     = $clog2(POP_MAX);
   localparam int CNT_W  = $clog2(POP_MAX + 1);
   localparam int WW     = (CNT_W > POPCFG_BITS) ? CNT_W : POPCFG_BITS;
   localparam int SUM_W  = FIT_BITS + CNT_W;
   localparam int PROD_W = SUM_W + RAND_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SUM  = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;
   localparam logic [1:0] S_SCAN = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic                 rdv_ff, rdv_in;
   logic [AW-1:0]        didx_ff, didx_in;
   logic [SUM_W-1:0]     acc_ff, acc_in;
   logic [SUM_W-1:0]     total_ff, total_in;
   logic [RAND_BITS-1:0] frac_ff, frac_in;
   logic [PROD_W-1:0]    ptr_ff, ptr_in;

   logic [WW-1:0]        pop_w;
   logic [WW-1:0]        n_eff;
   logic                 issue;
   logic [SUM_W-1:0]     sum;
   logic                 hit;
   logic                 last;

   assign pop_w = WW'(pop_count);
   assign n_eff = (pop_w == WW'(0)) ? WW'(1) :
                  (pop_w > WW'(POP_MAX)) ? WW'(POP_MAX) : pop_w;

   assign issue   = ((state_ff == S_SUM) || (state_ff == S_SCAN)) && (cnt_ff < n_ff);
   assign rd_addr = cnt_ff[AW-1:0];
   assign sum     = acc_ff + (rdv_ff ? SUM_W'(rd_data) : SUM_W'(0));
   assign hit     = {sum, RAND_BITS'(0)} >= ptr_ff;
   assign last    = CNT_W'(didx_ff) == (n_ff - CNT_W'(1));
   assign busy    = state_ff != S_IDLE;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      rdv_in       = rdv_ff;
      didx_in      = didx_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      frac_in      = frac_ff;
      ptr_in       = ptr_ff;
      result.valid = 1'b0;
      result.index = IDX_BITS'(didx_ff);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in     = CNT_W'(n_eff);
               frac_in  = random_fraction;
               cnt_in   = '0;
               rdv_in   = 1'b0;
               acc_in   = '0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            acc_in  = sum;
            rdv_in  = issue;
            didx_in = cnt_ff[AW-1:0];
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (cnt_ff == n_ff) begin
               total_in = sum;
               acc_in   = '0;
               cnt_in   = '0;
               rdv_in   = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            ptr_in   = PROD_W'(total_ff) * PROD_W'(frac_ff);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            acc_in  = sum;
            rdv_in  = issue;
            didx_in = cnt_ff[AW-1:0];
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (rdv_ff && (hit || last)) begin
               result.valid = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rdv_ff   <= rdv_in;
      end
      n_ff     <= n_in;
      didx_ff  <= didx_in;
      acc_ff   <= acc_in;
      total_ff <= total_in;
      frac_ff  <= frac_in;
      ptr_ff   <= ptr_in;
   end

endmodule

// ===== hw/rtl/gps_tournament.sv =====
// Tournament selection: running best challenger and challenger count.
// Depends on gps_pkg; takes read data from the fitness RAM.
module gps_tournament
   import gps_pkg::*;
#(
   parameter int POP_MAX = POP_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [IDX_BITS-1:0]   entry_index,
   input  logic [TSIZE_BITS-1:0] tournament_size,
   input  logic [FIT_BITS-1:0]   rd_data,
   output logic                  busy,
   output sel_type               result
);

   logic                  pend_ff;
   logic [IDX_BITS-1:0]   idx_ff;
   logic                  oob_ff;
   logic [TCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [FIT_BITS-1:0]   best_fit_ff, best_fit_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic                  best_vld_ff, best_vld_in;

   logic [FIT_BITS-1:0]   fit;
   logic                  new_best;
   logic [TSIZE_BITS-1:0] tsize_eff;
   logic                  done;
   logic [IDX_BITS-1:0]   win_idx;

   assign fit       = oob_ff ? '0 : rd_data;
   assign new_best  = !best_vld_ff || (fit > best_fit_ff);
   assign win_idx   = new_best ? idx_ff : best_idx_ff;
   assign tsize_eff = (tournament_size == '0) ? TSIZE_BITS'(1) :
                      (tournament_size > TSIZE_BITS'(TSIZE_MAX)) ? TSIZE_BITS'(TSIZE_MAX) :
                      tournament_size;
   assign done      = (TSIZE_BITS'(cnt_ff) + TSIZE_BITS'(1)) >= tsize_eff;
   assign busy      = pend_ff;

   always_comb begin
      cnt_in       = cnt_ff;
      best_fit_in  = best_fit_ff;
      best_idx_in  = best_idx_ff;
      best_vld_in  = best_vld_ff;
      result.valid = 1'b0;
      result.index = win_idx;
      if (pend_ff) begin
         if (done) begin
            result.valid = 1'b1;
            cnt_in       = '0;
            best_fit_in  = '0;
            best_idx_in  = '0;
            best_vld_in  = 1'b0;
         end else begin
            cnt_in      = cnt_ff + TCNT_BITS'(1);
            best_fit_in = new_best ? fit : best_fit_ff;
            best_idx_in = win_idx;
            best_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= 1'b0;
         cnt_ff      <= '0;
         best_fit_ff <= '0;
         best_idx_ff <= '0;
         best_vld_ff <= 1'b0;
      end else begin
         pend_ff     <= start;
         cnt_ff      <= cnt_in;
         best_fit_ff <= best_fit_in;
         best_idx_ff <= best_idx_in;
         best_vld_ff <= best_vld_in;
      end
      if (start) begin
         idx_ff <= entry_index;
         oob_ff <= 32'(entry_index) >= 32'(POP_MAX);
      end
   end

endmodule

// ===== hw/rtl/ga_parent_selection.sv =====
// Top level of the GA parent selection block.
// Depends on gps_pkg, gps_ram, gps_roulette and gps_tournament.
//
// Usage:
//   A command transfers at a rising edge with start high and busy low.
//   req_operation selects: load fitness (req_entry_index, req_fitness_value),
//   roulette draw (req_random_fraction) or tournament challenger
//   (req_entry_index). Other codes are dropped.
//   A load completes in the cycle of its transfer and gives no result.
//   A tournament challenger holds busy for one cycle; when it closes a
//   tournament the winner passes the RAM read and response registers.
//   A roulette draw holds busy while it totals the first n entries, n being
//   the clamped pop_count, through the shared adder, takes a multiply
//   step, then scans the entries through the same adder until a hit or entry n,
//   one RAM read per cycle. The result is registered as busy falls.
//   Each result sits on the rsp_ ports for one cycle with rsp_valid high;
//   the receiver cannot stall it. csr_ writes take effect at once;
//   the user makes them only while the block is idle; the block does not
//   enforce this. Reset sets pop_count to 64, tournament_size to 2 and
//   clears the tournament; fitness entries are undefined until loaded.
module ga_parent_selection
   import gps_pkg::*;
#(
   parameter int POP_MAX = POP_MAX_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_operation,
   input  logic [IDX_BITS-1:0]     req_entry_index,
   input  logic [FIT_BITS-1:0]     req_fitness_value,
   input  logic [RAND_BITS-1:0]    req_random_fraction,
   output logic                    rsp_valid,
   output logic [IDX_BITS-1:0]     rsp_selected_index,
   output logic                    rsp_selection_kind,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   localparam int AW = $clog2(POP_MAX);

   logic [POPCFG_BITS-1:0] pop_count_ff;
   logic [TSIZE_BITS-1:0]  tsize_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0]    rsp_index_ff, rsp_index_in;
   logic                   rsp_kind_ff, rsp_kind_in;

   logic                   accept;
   logic                   wr_en;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          rl_addr;
   logic [FIT_BITS-1:0]    rd_data;
   logic                   rl_busy;
   logic                   tn_busy;
   sel_type                rl_result;
   sel_type                tn_result;

   assign accept = start && !busy;
   assign busy   = rl_busy || tn_busy;
   assign wr_en  = accept && (req_operation == OP_LOAD) &&
                   (32'(req_entry_index) < 32'(POP_MAX));
   assign rd_addr = rl_busy ? rl_addr : AW'(req_entry_index);

   gps_ram #(
      .WIDTH(FIT_BITS),
      .DEPTH(POP_MAX)
   ) u_fit_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(AW'(req_entry_index)),
      .wr_data(req_fitness_value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   gps_roulette #(
      .POP_MAX(POP_MAX)
   ) u_roulette (
      .clock          (clock),
      .reset          (reset),
      .start          (accept && (req_operation == OP_ROULETTE)),
      .pop_count      (pop_count_ff),
      .random_fraction(req_random_fraction),
      .rd_data        (rd_data),
      .rd_addr        (rl_addr),
      .busy           (rl_busy),
      .result         (rl_result)
   );

   gps_tournament #(
      .POP_MAX(POP_MAX)
   ) u_tournament (
      .clock          (clock),
      .reset          (reset),
      .start          (accept && (req_operation == OP_TOURN)),
      .entry_index    (req_entry_index),
      .tournament_size(tsize_ff),
      .rd_data        (rd_data),
      .busy           (tn_busy),
      .result         (tn_result)
   );

   always_comb begin
      rsp_valid_in = rl_result.valid || tn_result.valid;
      rsp_index_in = rl_result.valid ? rl_result.index : tn_result.index;
      rsp_kind_in  = rl_result.valid ? KIND_ROULETTE : KIND_TOURN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_count_ff <= POP_COUNT_RST;
         tsize_ff     <= TSIZE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_POP_COUNT: pop_count_ff <= csr_wdata[POPCFG_BITS-1:0];
               CSR_TSIZE:     tsize_ff     <= csr_wdata[TSIZE_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
      rsp_index_ff <= rsp_index_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_index = rsp_index_ff;
   assign rsp_selection_kind = rsp_kind_ff;

endmodule
